// ===== rtl/hnd_pkg.sv =====
// Shared types, constants and bit-count functions for the Hamming
// nearest-descriptor core. No dependencies.
package hnd_pkg;

  localparam int unsigned MAX_CANDIDATES = 1024;
  localparam int unsigned CAND_CAP       = (MAX_CANDIDATES < 1024) ? MAX_CANDIDATES : 1024;
  localparam int unsigned DESC_WORDS     = 4;
  localparam int unsigned WORD_W         = 64;
  localparam int unsigned WONES_W        = 7;
  localparam int unsigned DIST_W         = 9;
  localparam int unsigned INDEX_W        = 10;
  localparam int unsigned COUNT_W        = 11;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned CFG_ADDR_W     = 3;
  localparam int unsigned WQ_DEPTH       = 4;
  localparam int unsigned WQ_PTR_W       = 2;
  localparam int unsigned RQ_DEPTH       = 4;
  localparam int unsigned RQ_PTR_W       = 2;
  localparam int unsigned FILL_W         = 3;

  localparam logic [DIST_W-1:0] INITIAL_BEST_RESET = 9'd256;
  localparam logic [DIST_W-1:0] MATCH_LIMIT_RESET  = 9'd100;

  typedef enum logic {
    KIND_QUERY     = 1'b0,
    KIND_CANDIDATE = 1'b1
  } kind_t;

  typedef enum logic {
    REG_INITIAL_BEST = 1'b0,
    REG_MATCH_LIMIT  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    kind_t                                kind;
    logic                                 last;
    logic [DESC_WORDS-1:0][WONES_W-1:0]   word_ones;
  } work_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] best_index;
    logic [DIST_W-1:0]  best_distance;
    logic               matched;
    logic               overflow;
  } result_t;

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

  function automatic logic [WONES_W-1:0] ones64(input logic [WORD_W-1:0] v);
    logic [WONES_W-1:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, ones8(v[8*i +: 8])};
    end
    return n;
  endfunction

endpackage

// ===== rtl/hnd_front.sv =====
// Front end: accepts items, holds the query descriptor and counts the
// differing bits of each candidate word. Depends on hnd_pkg.
module hnd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      kind,
  input  logic [63:0]               desc_word0,
  input  logic [63:0]               desc_word1,
  input  logic [63:0]               desc_word2,
  input  logic [63:0]               desc_word3,
  input  logic                      last,
  output logic                      wq_push,
  output hnd_pkg::work_item_t       wq_item,
  input  logic                      wq_full
);
  import hnd_pkg::*;

  logic [DESC_WORDS-1:0][WORD_W-1:0] query;
  logic [DESC_WORDS-1:0][WORD_W-1:0] desc;
  kind_t                             item_kind;

  assign desc      = {desc_word3, desc_word2, desc_word1, desc_word0};
  assign item_kind = kind_t'(kind);
  assign full      = wq_full;
  assign wq_push   = push && !wq_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      query <= '0;
    end else if (wq_push && item_kind == KIND_QUERY) begin
      query <= desc;
    end
  end

  always_comb begin
    wq_item.kind = item_kind;
    wq_item.last = last;
    for (int w = 0; w < DESC_WORDS; w++) begin
      wq_item.word_ones[w] = ones64(query[w] ^ desc[w]);
    end
  end

endmodule

// ===== rtl/hnd_work_queue.sv =====
// Short queue of classified items between front and back end.
// Depends on hnd_pkg.
module hnd_work_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hnd_pkg::work_item_t push_item,
  output logic                full,
  input  logic                pop,
  output hnd_pkg::work_item_t head,
  output logic                empty
);
  import hnd_pkg::*;

  work_item_t           slots [WQ_DEPTH];
  logic [WQ_PTR_W-1:0]  wr_ptr;
  logic [WQ_PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0]    fill;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (fill == FILL_W'(WQ_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/hnd_back.sv =====
// Back end: sums word distances, tracks the running best and queues
// results for the consumer. Depends on hnd_pkg.
module hnd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [hnd_pkg::DIST_W-1:0] initial_best,
  input  logic [hnd_pkg::DIST_W-1:0] match_limit,
  input  logic                       wq_empty,
  input  hnd_pkg::work_item_t        wq_head,
  output logic                       wq_pop,
  output logic                       empty,
  input  logic                       pop,
  output hnd_pkg::result_t           result
);
  import hnd_pkg::*;

  logic                 s1_valid;
  kind_t                s1_kind;
  logic                 s1_last;
  logic [DIST_W-1:0]    s1_dist;
  logic [DIST_W-1:0]    wq_dist;

  logic [DIST_W-1:0]    best_distance;
  logic [INDEX_W-1:0]   best_index;
  logic [COUNT_W-1:0]   count;
  logic [DIST_W-1:0]    best_distance_next;
  logic [INDEX_W-1:0]   best_index_next;
  logic [COUNT_W-1:0]   count_next;
  logic [DIST_W-1:0]    cur_dist;
  logic [DIST_W-1:0]    upd_dist;
  logic [INDEX_W-1:0]   upd_index;
  logic [COUNT_W-1:0]   upd_count;

  result_t              rq_slots [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]  rq_wr_ptr;
  logic [RQ_PTR_W-1:0]  rq_rd_ptr;
  logic [FILL_W-1:0]    rq_fill;
  logic                 rq_push;
  logic                 rq_pop;
  result_t              rq_item;
  logic                 s1_pending;

  assign wq_dist = DIST_W'(wq_head.word_ones[0]) + DIST_W'(wq_head.word_ones[1])
                 + DIST_W'(wq_head.word_ones[2]) + DIST_W'(wq_head.word_ones[3]);

  assign s1_pending = s1_valid && s1_last && (s1_kind == KIND_CANDIDATE);
  assign wq_pop     = !wq_empty &&
                      (({1'b0, rq_fill} + {3'b000, s1_pending}) < (FILL_W + 1)'(RQ_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= wq_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (wq_pop) begin
      s1_kind <= wq_head.kind;
      s1_last <= wq_head.last;
      s1_dist <= wq_dist;
    end
  end

  always_comb begin
    cur_dist = (count == '0) ? initial_best : best_distance;
    if (count < COUNT_W'(CAND_CAP)) begin
      upd_count = count + 1'b1;
      if (s1_dist < cur_dist) begin
        upd_dist  = s1_dist;
        upd_index = count[INDEX_W-1:0];
      end else begin
        upd_dist  = cur_dist;
        upd_index = best_index;
      end
    end else begin
      upd_count = COUNT_W'(CAND_CAP + 1);
      upd_dist  = cur_dist;
      upd_index = best_index;
    end

    rq_item.best_index    = upd_index;
    rq_item.best_distance = upd_dist;
    rq_item.matched       = (upd_dist < match_limit);
    rq_item.overflow      = (upd_count > COUNT_W'(CAND_CAP));

    rq_push            = 1'b0;
    best_distance_next = best_distance;
    best_index_next    = best_index;
    count_next         = count;
    if (s1_valid) begin
      if (s1_kind == KIND_QUERY || s1_last) begin
        rq_push            = (s1_kind == KIND_CANDIDATE);
        best_distance_next = initial_best;
        best_index_next    = '0;
        count_next         = '0;
      end else begin
        best_distance_next = upd_dist;
        best_index_next    = upd_index;
        count_next         = upd_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance <= INITIAL_BEST_RESET;
      best_index    <= '0;
      count         <= '0;
    end else begin
      best_distance <= best_distance_next;
      best_index    <= best_index_next;
      count         <= count_next;
    end
  end

  assign empty  = (rq_fill == '0);
  assign rq_pop = pop && !empty;
  assign result = rq_slots[rq_rd_ptr];

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_slots[rq_wr_ptr] <= rq_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr_ptr <= '0;
      rq_rd_ptr <= '0;
      rq_fill   <= '0;
    end else begin
      if (rq_push) begin
        rq_wr_ptr <= rq_wr_ptr + 1'b1;
      end
      if (rq_pop) begin
        rq_rd_ptr <= rq_rd_ptr + 1'b1;
      end
      if (rq_push && !rq_pop) begin
        rq_fill <= rq_fill + 1'b1;
      end else if (rq_pop && !rq_push) begin
        rq_fill <= rq_fill - 1'b1;
      end
    end
  end

  a_rq_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rq_push |-> (rq_fill < FILL_W'(RQ_DEPTH)) || rq_pop)
    else $error("result queue overrun");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAND_CAP + 1))
    else $error("candidate count out of range");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    rq_push |=> (count == '0) && (best_index == '0))
    else $error("search not cleared after result");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    wq_pop |=> (rq_fill + {2'b00, s1_pending}) <= FILL_W'(RQ_DEPTH))
    else $error("result credit exceeded");

endmodule

// ===== rtl/hamming_nearest_descriptor_core.sv =====
// Hamming nearest-descriptor core: top level with configuration registers.
// Depends on hnd_pkg, hnd_front, hnd_work_queue and hnd_back.
//
// Usage:
//   Items enter through push/full. kind 0 loads the 256-bit query from
//   desc_word0..3 and restarts the search; kind 1 is a candidate. The
//   candidate with last high closes the search and yields one result.
//   Results leave through empty/pop; the oldest result sits on the result
//   ports while empty is low.
//   Throughput: one item per cycle while the result queue has room. The
//   front counts differing bits per 64-bit word, the back sums the four
//   counts and compares with the running best; only that compare feeds
//   back between candidates. Path: work queue, stage s1, then the
//   result queue, whose oldest entry drives the result ports.
//   Stall: while pop stays low, up to four results wait in the result
//   queue, then the four-entry work queue fills and full rises.
//   Reset: queues empty, query zero, initial_best 256, match_limit 100.
//   Registers at byte address 0 (initial_best) and 4 (match_limit) are
//   to be written by the user only while the core is idle, which the core
//   does not enforce; initial_best applies from the next search.
module hamming_nearest_descriptor_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           kind,
  input  logic [63:0]                    desc_word0,
  input  logic [63:0]                    desc_word1,
  input  logic [63:0]                    desc_word2,
  input  logic [63:0]                    desc_word3,
  input  logic                           last,
  output logic                           empty,
  input  logic                           pop,
  output logic [hnd_pkg::INDEX_W-1:0]    best_index,
  output logic [hnd_pkg::DIST_W-1:0]     best_distance,
  output logic                           matched,
  output logic                           overflow,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hnd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hnd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [hnd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import hnd_pkg::*;

  logic [DIST_W-1:0] initial_best;
  logic [DIST_W-1:0] match_limit;
  cfg_reg_t          reg_sel;
  logic              cfg_write;

  logic              wq_push;
  work_item_t        wq_item;
  logic              wq_full;
  logic              wq_pop;
  work_item_t        wq_head;
  logic              wq_empty;
  result_t           result;

  assign pready    = 1'b1;
  assign reg_sel   = cfg_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_best <= INITIAL_BEST_RESET;
      match_limit  <= MATCH_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_INITIAL_BEST: initial_best <= pwdata[DIST_W-1:0];
        REG_MATCH_LIMIT:  match_limit  <= pwdata[DIST_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_INITIAL_BEST: prdata = CFG_DATA_W'(initial_best);
      REG_MATCH_LIMIT:  prdata = CFG_DATA_W'(match_limit);
      default:          prdata = '0;
    endcase
  end

  hnd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .desc_word0 (desc_word0),
    .desc_word1 (desc_word1),
    .desc_word2 (desc_word2),
    .desc_word3 (desc_word3),
    .last       (last),
    .wq_push    (wq_push),
    .wq_item    (wq_item),
    .wq_full    (wq_full)
  );

  hnd_work_queue u_work_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (wq_push),
    .push_item (wq_item),
    .full      (wq_full),
    .pop       (wq_pop),
    .head      (wq_head),
    .empty     (wq_empty)
  );

  hnd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .initial_best (initial_best),
    .match_limit  (match_limit),
    .wq_empty     (wq_empty),
    .wq_head      (wq_head),
    .wq_pop       (wq_pop),
    .empty        (empty),
    .pop          (pop),
    .result       (result)
  );

  assign best_index    = result.best_index;
  assign best_distance = result.best_distance;
  assign matched       = result.matched;
  assign overflow      = result.overflow;

endmodule

// ===== bench/hamming_nearest_descriptor_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for hamming_nearest_descriptor_core: drives query and
// candidate items, predicts each search result and checks it. Needs hnd_pkg.
module hamming_nearest_descriptor_core_tb;
  import hnd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 300;

  typedef struct packed {
    kind_t        kind;
    logic [255:0] desc;
    logic         last;
  } desc_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic kind;
  logic [63:0] desc_word0, desc_word1, desc_word2, desc_word3;
  logic last;
  logic empty;
  logic pop = 1'b0;
  logic [INDEX_W-1:0] best_index;
  logic [DIST_W-1:0] best_distance;
  logic matched;
  logic overflow;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  desc_item_t on_port = '0;
  desc_item_t item_feed[$];
  result_t nearest_due[$];
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic hold_arm = 1'b0;
  int unsigned hold_count = 0;
  logic hold_on;
  logic [255:0] gen_query = '0;

  logic [255:0] q_desc = '0;
  logic [DIST_W-1:0] run_best = INITIAL_BEST_RESET;
  logic [INDEX_W-1:0] run_idx = '0;
  int unsigned cand_seen = 0;
  logic [DIST_W-1:0] reg_initial_best = INITIAL_BEST_RESET;
  logic [DIST_W-1:0] reg_match_limit = MATCH_LIMIT_RESET;

  hamming_nearest_descriptor_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .desc_word0(desc_word0), .desc_word1(desc_word1),
    .desc_word2(desc_word2), .desc_word3(desc_word3), .last(last),
    .empty(empty), .pop(pop), .best_index(best_index),
    .best_distance(best_distance), .matched(matched), .overflow(overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  assign kind       = on_port.kind;
  assign desc_word0 = on_port.desc[63:0];
  assign desc_word1 = on_port.desc[127:64];
  assign desc_word2 = on_port.desc[191:128];
  assign desc_word3 = on_port.desc[255:192];
  assign last       = on_port.last;
  assign hold_on    = hold_arm && (hold_count < HOLD_CYCLES);

  always #5 clk = ~clk;

  function automatic logic [DIST_W-1:0] hamming256(logic [255:0] a, logic [255:0] b);
    logic [255:0] x;
    logic [DIST_W-1:0] n;
    x = a ^ b;
    n = '0;
    for (int i = 0; i < 256; i++) n = n + DIST_W'(x[i]);
    return n;
  endfunction

  task automatic restart_search();
    run_best  = reg_initial_best;
    run_idx   = '0;
    cand_seen = 0;
  endtask

  task automatic advance_search(input desc_item_t it);
    logic [DIST_W-1:0] d;
    result_t r;
    if (it.kind == KIND_QUERY) begin
      q_desc = it.desc;
      restart_search();
      return;
    end
    if (cand_seen == 0) run_best = reg_initial_best;
    if (cand_seen < CAND_CAP) begin
      d = hamming256(q_desc, it.desc);
      if (d < run_best) begin
        run_best = d;
        run_idx  = cand_seen[INDEX_W-1:0];
      end
      cand_seen++;
    end else begin
      cand_seen = CAND_CAP + 1;
    end
    if (it.last) begin
      r.best_index    = run_idx;
      r.best_distance = run_best;
      r.matched       = run_best < reg_match_limit;
      r.overflow      = cand_seen > CAND_CAP;
      nearest_due = {nearest_due, r};
      restart_search();
    end
  endtask

  task automatic note_mismatch(string msg);
    if (mismatches < 10) $display("MISMATCH %s", msg);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) note_mismatch($sformatf("%s: expected %0d, got %0d", what, want, got));
  endtask

  // Drive items from the feed queue, predicting each one as it is accepted.
  always @(posedge clk) begin : drive_items
    desc_item_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        advance_search(on_port);
        items_accepted++;
      end
      if (!(push && full)) begin
        if (item_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = item_feed.pop_front();
          on_port <= nxt;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (nearest_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result index %0d distance %0d",
                                  best_index, best_distance));
        end else begin
          want = nearest_due.pop_front();
          check_field("best_index", 32'(want.best_index), 32'(best_index));
          check_field("best_distance", 32'(want.best_distance), 32'(best_distance));
          check_field("matched", 32'(want.matched), 32'(matched));
          check_field("overflow", 32'(want.overflow), 32'(overflow));
        end
      end
      pop <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : count_hold
    if (rst || !hold_arm) hold_count <= 0;
    else if (hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [DIST_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {23'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_INITIAL_BEST) reg_initial_best = v;
    else reg_match_limit = v;
  endtask

  task automatic read_reg_check(cfg_reg_t r, logic [DIST_W-1:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field(r == REG_INITIAL_BEST ? "initial_best read" : "match_limit read",
                {23'b0, want}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_regs(logic [DIST_W-1:0] ib, logic [DIST_W-1:0] ml);
    write_reg(REG_INITIAL_BEST, ib);
    write_reg(REG_MATCH_LIMIT, ml);
    read_reg_check(REG_INITIAL_BEST, ib);
    read_reg_check(REG_MATCH_LIMIT, ml);
  endtask

  task automatic set_random_regs();
    logic [DIST_W-1:0] ib;
    logic [DIST_W-1:0] ml;
    case ($urandom_range(3))
      0:       ib = 9'd256;
      3:       ib = DIST_W'($urandom_range(257, 511));
      default: ib = DIST_W'($urandom_range(0, 256));
    endcase
    ml = ($urandom_range(4) == 0) ? DIST_W'($urandom_range(258, 511))
                                  : DIST_W'($urandom_range(0, 257));
    set_regs(ib, ml);
  endtask

  // Hold until every item is taken, every result checked and the pipe is quiet.
  task automatic settle();
    while (items_accepted != items_queued || nearest_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_item(kind_t k, logic [255:0] d, logic l);
    desc_item_t it;
    it.kind = k;
    it.desc = d;
    it.last = l;
    item_feed = {item_feed, it};
    items_queued++;
  endtask

  function automatic logic [255:0] random256();
    logic [255:0] r;
    for (int i = 0; i < 8; i++) r[32*i +: 32] = $urandom;
    return r;
  endfunction

  function automatic logic [255:0] flip_bits(logic [255:0] v, int unsigned k);
    logic [255:0] r;
    r = v;
    for (int unsigned i = 0; i < k; i++) r = r ^ (256'b1 << $urandom_range(255));
    return r;
  endfunction

  function automatic logic [255:0] pick_candidate(logic [255:0] prev);
    case ($urandom_range(9))
      0, 1:    return random256();
      2:       return ~gen_query;
      3:       return gen_query;
      4:       return prev;
      default: return flip_bits(gen_query, ($urandom_range(3) == 0) ?
                                $urandom_range(0, 200) : $urandom_range(0, 12));
    endcase
  endfunction

  // Mostly well-formed searches; some skip the query load or drop the last flag.
  task automatic queue_random_searches(int unsigned budget);
    int unsigned sent;
    int unsigned n;
    logic broken;
    logic [255:0] prev;
    logic [255:0] c;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(9) != 0) begin
        gen_query = random256();
        queue_item(KIND_QUERY, gen_query, 1'($urandom_range(1)));
        sent++;
      end
      n = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      broken = ($urandom_range(11) == 0);
      prev = gen_query;
      for (int unsigned i = 0; i < n; i++) begin
        c = pick_candidate(prev);
        queue_item(KIND_CANDIDATE, c, (i == n - 1) && !broken);
        prev = c;
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [255:0] q;
    send_idle_pct <= 13;
    recv_idle_pct <= 48;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_reg_check(REG_INITIAL_BEST, INITIAL_BEST_RESET);
    read_reg_check(REG_MATCH_LIMIT, MATCH_LIMIT_RESET);

    queue_item(KIND_CANDIDATE, '1, 1'b1);
    queue_item(KIND_QUERY, '1, 1'b1);
    queue_item(KIND_CANDIDATE, '1, 1'b0);
    queue_item(KIND_CANDIDATE, '1, 1'b1);
    q = random256();
    queue_item(KIND_QUERY, q, 1'b0);
    queue_item(KIND_CANDIDATE, ~q, 1'b0);
    queue_item(KIND_CANDIDATE, q ^ (256'b1 << 255), 1'b0);
    queue_item(KIND_CANDIDATE, q ^ 256'b1, 1'b0);
    queue_item(KIND_CANDIDATE, q, 1'b1);
    queue_item(KIND_CANDIDATE, flip_bits(q, 40), 1'b0);
    queue_item(KIND_QUERY, '0, 1'b0);
    queue_item(KIND_CANDIDATE, 256'b1 << 64, 1'b1);
    settle();

    set_regs(9'd0, 9'd0);
    queue_item(KIND_CANDIDATE, random256(), 1'b1);
    queue_item(KIND_CANDIDATE, '0, 1'b1);
    settle();

    set_regs(9'd300, 9'd257);
    q = random256();
    queue_item(KIND_QUERY, q, 1'b0);
    queue_item(KIND_CANDIDATE, ~q, 1'b1);
    queue_item(KIND_CANDIDATE, flip_bits(q, 16), 1'b0);
    settle();

    set_regs(9'd511, 9'd511);
    queue_item(KIND_CANDIDATE, ~q, 1'b1);
    queue_item(KIND_CANDIDATE, ~q, 1'b0);
    queue_item(KIND_CANDIDATE, ~q ^ (256'b1 << 130), 1'b1);
    settle();

    set_regs(INITIAL_BEST_RESET, MATCH_LIMIT_RESET);
    queue_random_searches(130);
    settle();
    set_random_regs();
    queue_random_searches(130);
    settle();

    send_idle_pct <= 48;
    recv_idle_pct <= 13;
    set_random_regs();
    queue_random_searches(130);
    settle();
    set_random_regs();
    queue_random_searches(130);
    settle();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    set_random_regs();
    hold_arm <= 1'b1;
    queue_random_searches(80);
    settle();
    hold_arm <= 1'b0;

    set_regs(INITIAL_BEST_RESET, MATCH_LIMIT_RESET);
    queue_random_searches(100);
    settle();

    if (mismatches == 0 && nearest_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
